FILE: src/usbef_pkg.sv
// ----------------------------------------------------------------------------
// usbef_pkg
// Types and constants shared by the endpoint finder and its checker.
// ----------------------------------------------------------------------------
package usbef_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WANT_CLASS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANT_SUBCLASS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANT_PROTOCOL = 2'd2;

    localparam logic [7:0] WANT_CLASS_RST    = 8'hFF;
    localparam logic [7:0] WANT_SUBCLASS_RST = 8'h42;
    localparam logic [7:0] WANT_PROTOCOL_RST = 8'h01;

    localparam logic [7:0] KIND_INTERFACE = 8'h04;
    localparam logic [7:0] KIND_ENDPOINT  = 8'h05;
    localparam logic [7:0] MIN_HEADER_LEN = 8'd4;
    localparam logic [7:0] MIN_IFACE_LEN  = 8'd8;
    localparam logic [7:0] MIN_EP_LEN     = 8'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_mark;
    } in_t;

    typedef struct packed {
        logic       done_res;
        logic       found;
        logic       malformed;
        logic [7:0] interface_number;
        logic [7:0] in_endpoint;
        logic [7:0] out_endpoint;
    } out_t;

    typedef struct packed {
        logic [7:0] want_class;
        logic [7:0] want_subclass;
        logic [7:0] want_protocol;
    } cfg_t;

    typedef struct packed {
        logic [15:0] set_offset;
        logic [15:0] total_length;
        logic [7:0]  header_length;
        logic [7:0]  desc_position;
        logic [7:0]  desc_length;
        logic [7:0]  desc_kind;
        logic [7:0]  pending_number;
        logic        class_ok;
        logic        subclass_ok;
        logic        inside_match;
        logic [7:0]  matched_number;
        logic [7:0]  in_address;
        logic [7:0]  out_address;
        logic        halted;
        logic        bad_flag;
    } state_t;

endpackage

FILE: src/usb_interface_endpoint_finder.sv
// ----------------------------------------------------------------------------
// usb_interface_endpoint_finder
// Walks a configuration descriptor byte by byte, finds the matching interface
// and records its IN and OUT endpoint addresses.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  byte     | byte_valid, byte_stall, byte_data     | in, one descriptor byte
//  status   | status_valid, status_stall, status_data | out, one per byte
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in, register write
//
// one byte per cycle while byte_stall is low; its status is registered when
// the byte is taken. the parser state and the status register are
// loaded in the same edge, so the per-byte update is the only logic path.
// after reset the parser is idle and reports done until a start mark.
// byte_stall is high only while a status waits with status_stall high.
// ----------------------------------------------------------------------------
module usb_interface_endpoint_finder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  usbef_pkg::in_t                      byte_data,
    output logic                                status_valid,
    input  logic                                status_stall,
    output usbef_pkg::out_t                     status_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [usbef_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                          cfg_data
);

    usbef_pkg::state_t state_reg;
    usbef_pkg::state_t state_next;
    usbef_pkg::cfg_t   cfg_reg;
    usbef_pkg::out_t   status_reg;
    usbef_pkg::out_t   status_next;
    logic              status_valid_reg;
    logic              accept;

    assign byte_stall   = status_valid_reg && status_stall;
    assign accept       = byte_valid && !byte_stall;
    assign cfg_ready    = 1'b1;
    assign status_valid = status_valid_reg;
    assign status_data  = status_reg;

    usbef_step u_step
    (
        .cur    (state_reg),
        .item   (byte_data),
        .cfg    (cfg_reg),
        .nxt    (state_next),
        .result (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.want_class    <= usbef_pkg::WANT_CLASS_RST;
            cfg_reg.want_subclass <= usbef_pkg::WANT_SUBCLASS_RST;
            cfg_reg.want_protocol <= usbef_pkg::WANT_PROTOCOL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                usbef_pkg::CFG_WANT_CLASS:    cfg_reg.want_class    <= cfg_data;
                usbef_pkg::CFG_WANT_SUBCLASS: cfg_reg.want_subclass <= cfg_data;
                usbef_pkg::CFG_WANT_PROTOCOL: cfg_reg.want_protocol <= cfg_data;
                default:                      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '{halted: 1'b1, default: '0};
            status_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg        <= state_next;
            status_valid_reg <= 1'b1;
        end
        else if (!status_stall)
        begin
            status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

endmodule

FILE: src/usbef_step.sv
// ----------------------------------------------------------------------------
// usbef_step
// Per-byte parser update: next walker state and status for one byte.
// ----------------------------------------------------------------------------
module usbef_step
(
    input  usbef_pkg::state_t cur,
    input  usbef_pkg::in_t    item,
    input  usbef_pkg::cfg_t   cfg,
    output usbef_pkg::state_t nxt,
    output usbef_pkg::out_t   result
);

    usbef_pkg::state_t n;
    logic [7:0]  b;
    logic [15:0] o;
    logic [7:0]  pos;
    logic [7:0]  pos_inc;
    logic [16:0] desc_end;
    logic [15:0] off_inc;

    always_comb
    begin
        n        = cur;
        b        = item.data_byte;
        o        = 16'd0;
        pos      = 8'd0;
        pos_inc  = 8'd0;
        desc_end = 17'd0;
        off_inc  = 16'd0;

        if (item.start_mark)
        begin
            n.set_offset     = 16'd0;
            n.total_length   = 16'd0;
            n.header_length  = 8'd0;
            n.desc_position  = 8'd0;
            n.desc_length    = 8'd0;
            n.desc_kind      = 8'd0;
            n.pending_number = 8'd0;
            n.class_ok       = 1'b0;
            n.subclass_ok    = 1'b0;
            n.inside_match   = 1'b0;
            n.in_address     = 8'd0;
            n.out_address    = 8'd0;
            n.halted         = 1'b0;
            n.bad_flag       = 1'b0;
        end

        if (!n.halted)
        begin
            o = n.set_offset;

            // header fields
            if (o == 16'd0)
            begin
                n.header_length = b;
                if (b < usbef_pkg::MIN_HEADER_LEN)
                begin
                    n.halted   = 1'b1;
                    n.bad_flag = 1'b1;
                end
            end
            else if (o == 16'd2)
            begin
                n.total_length[7:0] = b;
            end
            else if (o == 16'd3)
            begin
                n.total_length[15:8] = b;
                if ({b, n.total_length[7:0]} <= {8'd0, n.header_length})
                begin
                    n.halted = 1'b1;
                end
            end

            // descriptor walk past the header
            if (!n.halted && o >= 16'd4 && o >= {8'd0, n.header_length})
            begin
                pos      = n.desc_position;
                desc_end = {1'b0, o} + {9'd0, b};
                if (pos == 8'd0)
                begin
                    if (b == 8'd0 || desc_end > {1'b0, n.total_length})
                    begin
                        n.halted   = 1'b1;
                        n.bad_flag = 1'b1;
                    end
                    else
                    begin
                        n.desc_length = b;
                        n.desc_kind   = 8'd0;
                    end
                end
                else if (pos == 8'd1)
                begin
                    n.desc_kind = b;
                    if (b == usbef_pkg::KIND_INTERFACE)
                    begin
                        n.inside_match = 1'b0;
                        n.class_ok     = 1'b0;
                        n.subclass_ok  = 1'b0;
                    end
                end
                else if (n.desc_kind == usbef_pkg::KIND_INTERFACE &&
                         n.desc_length >= usbef_pkg::MIN_IFACE_LEN)
                begin
                    if (pos == 8'd2)
                    begin
                        n.pending_number = b;
                    end
                    else if (pos == 8'd5)
                    begin
                        n.class_ok = (b == cfg.want_class);
                    end
                    else if (pos == 8'd6)
                    begin
                        n.subclass_ok = (b == cfg.want_subclass);
                    end
                    else if (pos == 8'd7)
                    begin
                        if (n.class_ok && n.subclass_ok && b == cfg.want_protocol)
                        begin
                            n.inside_match   = 1'b1;
                            n.matched_number = n.pending_number;
                        end
                        else
                        begin
                            n.inside_match = 1'b0;
                        end
                    end
                end
                else if (n.desc_kind == usbef_pkg::KIND_ENDPOINT &&
                         n.desc_length >= usbef_pkg::MIN_EP_LEN &&
                         pos == 8'd2 && n.inside_match)
                begin
                    if (b[7])
                    begin
                        n.in_address = b;
                    end
                    else
                    begin
                        n.out_address = b;
                    end
                end

                if (!n.halted)
                begin
                    pos_inc         = pos + 8'd1;
                    n.desc_position = (pos_inc >= n.desc_length) ? 8'd0 : pos_inc;
                end
            end

            if (!n.halted)
            begin
                off_inc      = o + 16'd1;
                n.set_offset = off_inc;
                if (off_inc >= 16'd4 && off_inc >= n.total_length)
                begin
                    n.halted = 1'b1;
                end
            end
        end

        nxt                     = n;
        result.done_res         = n.halted;
        result.found            = (n.in_address != 8'd0) && (n.out_address != 8'd0);
        result.malformed        = n.bad_flag;
        result.interface_number = n.matched_number;
        result.in_endpoint      = n.in_address;
        result.out_endpoint     = n.out_address;
    end

endmodule

FILE: src/usbef_checker.sv
// ----------------------------------------------------------------------------
// usbef_checker
// Port-level checks of the endpoint finder, attached by bind.
// ----------------------------------------------------------------------------
module usbef_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              byte_valid,
    input logic                              byte_stall,
    input usbef_pkg::in_t                    byte_data,
    input logic                              status_valid,
    input logic                              status_stall,
    input usbef_pkg::out_t                   status_data
);

    // a held status request keeps its payload
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status_stall |=> status_valid && $stable(status_data))
        else $error("status changed while stalled");

    // input is only held back by a waiting status
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(status_valid && status_stall) |-> !byte_stall)
        else $error("byte stalled with no status waiting");

    // a start with a legal header length opens a fresh walk
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && byte_data.start_mark &&
        byte_data.data_byte >= usbef_pkg::MIN_HEADER_LEN
        |=> status_valid && !status_data.done_res && !status_data.malformed &&
            status_data.in_endpoint == 8'd0 && status_data.out_endpoint == 8'd0)
        else $error("start did not clear the walk");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> status_data.found ==
            (status_data.in_endpoint != 8'd0 && status_data.out_endpoint != 8'd0))
        else $error("found flag disagrees with endpoints");

    a_direction: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> !status_data.out_endpoint[7] &&
            (status_data.in_endpoint == 8'd0 || status_data.in_endpoint[7]))
        else $error("endpoint recorded with wrong direction");

endmodule

bind usb_interface_endpoint_finder usbef_checker u_usbef_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status_data  (status_data)
);
